/* rtl/core/jsu_pkg.sv */
`default_nettype none
package jsu_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_V   = 8'h76;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_HT = 8'h09;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_VT = 8'h0B;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_CR = 8'h0D;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_HEX2 = 2'd1;
    localparam logic [1:0] ERR_HEX4 = 2'd2;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_string;
    } item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       has_char;
        logic       final_res;
        logic [1:0] escape_error;
    } result_t;

    // results of one item, as handed from decoder to serializer
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] data;
        logic            has_char;
        logic [1:0]      err;
        logic            last;
    } desc_t;

    function automatic logic hex_ok(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
            || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/jsu_front.sv */
`default_nettype none
module jsu_front
    import jsu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  accept,
    input  wire item_t item,
    output desc_t      desc,
    output logic       desc_push
);

    localparam logic [1:0] PH_PLAIN = 2'd0;
    localparam logic [1:0] PH_ESC   = 2'd1;
    localparam logic [1:0] PH_HEX2  = 2'd2;
    localparam logic [1:0] PH_HEX4  = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  digits_reg, digits_next;
    logic [15:0] accum_reg, accum_next;
    logic        bad_reg, bad_next;
    logic [7:0]  held_reg [3];
    logic        held_we;

    always_comb
    begin
        logic [7:0]  c;
        logic        last;
        logic        quad;
        logic        done;
        logic [1:0]  herr;
        logic        nbad;
        logic [15:0] nacc;

        c    = item.char_in;
        last = item.end_of_string;
        quad = (phase_reg == PH_HEX4);
        herr = quad ? ERR_HEX4 : ERR_HEX2;
        done = quad ? (digits_reg == 2'd3) : (digits_reg != 2'd0);
        nbad = bad_reg | ~hex_ok(c);
        nacc = {accum_reg[11:0], hex_val(c)};

        phase_next  = phase_reg;
        digits_next = digits_reg;
        accum_next  = accum_reg;
        bad_next    = bad_reg;
        held_we     = 1'b0;

        desc          = '0;
        desc.has_char = 1'b1;
        desc.err      = ERR_NONE;
        desc.last     = last;

        unique case (phase_reg) inside
            PH_PLAIN:
            begin
                if (c == CH_BACKSLASH && !last)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    desc.cnt     = 2'd1;
                    desc.data[0] = c;
                end
            end
            PH_ESC:
            begin
                phase_next = PH_PLAIN;
                desc.cnt   = 2'd1;
                unique case (c) inside
                    CH_BACKSLASH: desc.data[0] = CH_BACKSLASH;
                    CH_SLASH:     desc.data[0] = CH_SLASH;
                    CH_QUOTE:     desc.data[0] = CH_QUOTE;
                    CH_LOWER_B:   desc.data[0] = CTL_BS;
                    CH_LOWER_T:   desc.data[0] = CTL_HT;
                    CH_LOWER_N:   desc.data[0] = CTL_LF;
                    CH_LOWER_V:   desc.data[0] = CTL_VT;
                    CH_LOWER_F:   desc.data[0] = CTL_FF;
                    CH_LOWER_R:   desc.data[0] = CTL_CR;
                    CH_LOWER_X, CH_LOWER_U:
                    begin
                        digits_next = 2'd0;
                        accum_next  = '0;
                        bad_next    = 1'b0;
                        if (last)
                        begin
                            desc.has_char = 1'b0;
                            desc.err      = (c == CH_LOWER_X) ? ERR_HEX2 : ERR_HEX4;
                        end
                        else
                        begin
                            desc.cnt   = 2'd0;
                            phase_next = (c == CH_LOWER_X) ? PH_HEX2 : PH_HEX4;
                        end
                    end
                    default:
                    begin
                        desc.cnt     = 2'd2;
                        desc.data[0] = CH_BACKSLASH;
                        desc.data[1] = c;
                    end
                endcase
            end
            PH_HEX2, PH_HEX4:
            begin
                if (done)
                begin
                    desc.cnt = 2'd1;
                    if (nbad)
                    begin
                        desc.data[0] = CH_QUESTION;
                        desc.err     = herr;
                    end
                    else if (!quad || nacc < 16'h0080)
                    begin
                        desc.data[0] = nacc[7:0];
                    end
                    else if (nacc < 16'h0800)
                    begin
                        desc.cnt     = 2'd2;
                        desc.data[0] = {3'b110, nacc[10:6]};
                        desc.data[1] = {2'b10, nacc[5:0]};
                    end
                    else
                    begin
                        desc.cnt     = 2'd3;
                        desc.data[0] = {4'b1110, nacc[15:12]};
                        desc.data[1] = {2'b10, nacc[11:6]};
                        desc.data[2] = {2'b10, nacc[5:0]};
                    end
                    phase_next  = PH_PLAIN;
                    digits_next = 2'd0;
                    accum_next  = '0;
                    bad_next    = 1'b0;
                end
                else if (last)
                begin
                    // string ends inside the escape: held digits go out raw
                    desc.cnt = digits_reg + 2'd1;
                    desc.err = herr;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (2'(i) < digits_reg)
                        begin
                            desc.data[i] = held_reg[i];
                        end
                        else if (2'(i) == digits_reg)
                        begin
                            desc.data[i] = c;
                        end
                    end
                end
                else
                begin
                    desc.cnt    = 2'd0;
                    held_we     = (digits_reg != 2'd3);
                    digits_next = digits_reg + 2'd1;
                    accum_next  = nacc;
                    bad_next    = nbad;
                end
            end
            default:
            begin
                phase_next = PH_PLAIN;
            end
        endcase

        if (last)
        begin
            phase_next  = PH_PLAIN;
            digits_next = 2'd0;
            accum_next  = '0;
            bad_next    = 1'b0;
        end
    end

    assign desc_push = accept && (desc.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PLAIN;
            digits_reg <= 2'd0;
            accum_reg  <= '0;
            bad_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            digits_reg <= digits_next;
            accum_reg  <= accum_next;
            bad_reg    <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && held_we)
        begin
            held_reg[digits_reg] <= item.char_in;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/jsu_queue.sv */
`default_nettype none
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire desc_t wr_desc,
    output logic       q_full,
    input  wire logic  rd_en,
    output desc_t      rd_desc,
    output logic       q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr, do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_desc = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/jsu_back.sv */
`default_nettype none
module jsu_back
    import jsu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire desc_t head,
    input  wire logic  head_empty,
    output logic       head_pop,
    output result_t    result,
    output logic       empty,
    input  wire logic  pop
);

    logic [1:0] idx_reg;
    logic       at_end;

    assign at_end   = (idx_reg == head.cnt - 2'd1);
    assign empty    = head_empty;
    assign head_pop = pop && !head_empty && at_end;

    always_comb
    begin
        result.char_out     = head.data[idx_reg];
        result.has_char     = head.has_char;
        result.final_res    = head.last && at_end;
        result.escape_error = head.err;
    end

    // walks the bytes of the head entry, one per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else if (pop && !head_empty)
        begin
            idx_reg <= at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/json_string_unescape_core.sv */
// JSON string unescape core: takes one string body byte per cycle while full is
// low and gives decoded bytes one per cycle while pop is high through a queue-style
// result port; a taken byte's results show once all older ones are taken. A decoder
// tracks escape state and turns each byte into zero to three result bytes; these
// wait in a queue of QUEUE_DEPTH entries and a serializer hands them out one per
// transfer, so a \u escape that yields three UTF-8 bytes holds the result side until
// all three are taken. full rises once QUEUE_DEPTH result groups of any size are
// waiting and falls the cycle after the serializer finishes the oldest group.
`default_nettype none
module json_string_unescape_core
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    output logic       empty,
    input  wire logic  pop,
    output result_t    result
);

    desc_t front_desc;
    desc_t head_desc;
    logic  front_push;
    logic  head_empty;
    logic  head_pop;
    logic  accept;

    assign accept = push && !full;

    jsu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .desc      (front_desc),
        .desc_push (front_push)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_desc (front_desc),
        .q_full  (full),
        .rd_en   (head_pop),
        .rd_desc (head_desc),
        .q_empty (head_empty)
    );

    jsu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_desc),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule
`default_nettype wire

/* rtl/core/jsu_checker.sv */
`default_nettype none
module jsu_checker
    import jsu_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    push,
    input wire logic    full,
    input wire item_t   item,
    input wire logic    empty,
    input wire logic    pop,
    input wire result_t result
);

    // a waiting result stays put until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed while waiting");

    // a bare marker only closes a string cut inside a hex escape
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.has_char |->
            result.final_res && result.char_out == 8'h00 && result.escape_error != ERR_NONE)
        else $error("bad bare marker");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.escape_error != 2'd3)
        else $error("bad error code");

    // a final byte always leaves something to read
    assert property (@(posedge clk) disable iff (!rst_n)
        push && !full && empty && item.end_of_string |=> !empty)
        else $error("final byte not delivered");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
`default_nettype wire

/* tb/sv/tb_json_string_unescape_core.sv */
module tb_json_string_unescape_core;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    localparam int RANDOM_BYTES   = 140;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    typedef enum logic [1:0] {PH_TEXT, PH_ESCAPE, PH_HEX2, PH_HEX4} phase_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       fixed;
        result_t    res;
    } stim_row_t;

    localparam result_t NO_FIXED = '0;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    pop   = 1'b0;
    item_t   item  = '0;
    logic    full;
    logic    empty;
    result_t result;

    // decoder copy
    phase_e      dec_phase = PH_TEXT;
    logic [1:0]  dec_count = 2'd0;
    logic [15:0] dec_code  = 16'd0;
    logic [7:0]  dec_held [3];
    logic        dec_bad   = 1'b0;
    result_t     step_res [$];

    result_t     decoded_due [$];
    logic [7:0]  body_bytes [$];
    int          mismatches  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    int          pat_left    = 0;
    logic [15:0] stall_pat   = 16'hFFFF;
    logic        drain       = 1'b0;

    logic [7:0] simple_esc [9] = '{CH_BACKSLASH, CH_SLASH, CH_QUOTE, CH_LOWER_B,
        CH_LOWER_T, CH_LOWER_N, CH_LOWER_V, CH_LOWER_F, CH_LOWER_R};
    logic [15:0] code_edges [6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
        16'h0800, 16'hFFFF};

    stim_row_t directed_rows [28] = '{
        {"A",          1'b0, 1'b1, {"A",          1'b1, 1'b0, ERR_NONE}},
        {8'h00,        1'b0, 1'b1, {8'h00,        1'b1, 1'b0, ERR_NONE}},
        {8'hFF,        1'b1, 1'b1, {8'hFF,        1'b1, 1'b1, ERR_NONE}},
        // lone backslash at the end of a string
        {CH_BACKSLASH, 1'b1, 1'b1, {CH_BACKSLASH, 1'b1, 1'b1, ERR_NONE}},
        // unknown escape
        {CH_BACKSLASH, 1'b0, 1'b0, NO_FIXED},
        {"q",          1'b0, 1'b0, NO_FIXED},
        // string ends right after \x
        {CH_BACKSLASH, 1'b0, 1'b0, NO_FIXED},
        {CH_LOWER_X,   1'b1, 1'b1, {8'h00,        1'b0, 1'b1, ERR_HEX2}},
        // bad \x digit
        {CH_BACKSLASH, 1'b0, 1'b0, NO_FIXED},
        {CH_LOWER_X,   1'b0, 1'b0, NO_FIXED},
        {"g",          1'b0, 1'b0, NO_FIXED},
        {"1",          1'b0, 1'b1, {CH_QUESTION,  1'b1, 1'b0, ERR_HEX2}},
        // three byte code
        {CH_BACKSLASH, 1'b0, 1'b0, NO_FIXED},
        {CH_LOWER_U,   1'b0, 1'b0, NO_FIXED},
        {"F",          1'b0, 1'b0, NO_FIXED},
        {"f",          1'b0, 1'b0, NO_FIXED},
        {"f",          1'b0, 1'b0, NO_FIXED},
        {"F",          1'b0, 1'b0, NO_FIXED},
        // string ends inside \u
        {CH_BACKSLASH, 1'b0, 1'b0, NO_FIXED},
        {CH_LOWER_U,   1'b0, 1'b0, NO_FIXED},
        {"0",          1'b0, 1'b0, NO_FIXED},
        {"7",          1'b1, 1'b0, NO_FIXED},
        // bad \u digits, backslash and quote used up as digits
        {CH_BACKSLASH, 1'b0, 1'b0, NO_FIXED},
        {CH_LOWER_U,   1'b0, 1'b0, NO_FIXED},
        {CH_BACKSLASH, 1'b0, 1'b0, NO_FIXED},
        {CH_QUOTE,     1'b0, 1'b0, NO_FIXED},
        {"z",          1'b0, 1'b0, NO_FIXED},
        {"9",          1'b0, 1'b1, {CH_QUESTION,  1'b1, 1'b0, ERR_HEX4}}
    };

    json_string_unescape_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // {valid, value} of one hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= "0" && c <= "9")
        begin
            v = c - "0";
            return {1'b1, v[3:0]};
        end
        if (c >= "a" && c <= "f")
        begin
            v = c - "a" + 8'd10;
            return {1'b1, v[3:0]};
        end
        if (c >= "A" && c <= "F")
        begin
            v = c - "A" + 8'd10;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic void emit(input logic [7:0] ch, input logic has,
                                 input logic [1:0] err);
        result_t r;
        r.char_out     = ch;
        r.has_char     = has;
        r.final_res    = 1'b0;
        r.escape_error = err;
        step_res = {step_res, r};
    endfunction

    function automatic void clear_escape();
        dec_phase = PH_TEXT;
        dec_count = 2'd0;
        dec_code  = 16'd0;
        dec_bad   = 1'b0;
    endfunction

    function automatic void decode_byte(input item_t it);
        logic [7:0]  c;
        logic        eos;
        logic        quad;
        logic [1:0]  err;
        logic [4:0]  hv;
        logic [15:0] code;
        int          need;
        int          have;
        c   = it.char_in;
        eos = it.end_of_string;
        step_res.delete();
        case (dec_phase)
            PH_TEXT:
            begin
                if (c == CH_BACKSLASH)
                begin
                    if (eos)
                        emit(CH_BACKSLASH, 1'b1, ERR_NONE);
                    else
                        dec_phase = PH_ESCAPE;
                end
                else
                begin
                    emit(c, 1'b1, ERR_NONE);
                end
            end
            PH_ESCAPE:
            begin
                dec_phase = PH_TEXT;
                case (c)
                    CH_BACKSLASH, CH_SLASH, CH_QUOTE: emit(c, 1'b1, ERR_NONE);
                    CH_LOWER_B: emit(CTL_BS, 1'b1, ERR_NONE);
                    CH_LOWER_T: emit(CTL_HT, 1'b1, ERR_NONE);
                    CH_LOWER_N: emit(CTL_LF, 1'b1, ERR_NONE);
                    CH_LOWER_V: emit(CTL_VT, 1'b1, ERR_NONE);
                    CH_LOWER_F: emit(CTL_FF, 1'b1, ERR_NONE);
                    CH_LOWER_R: emit(CTL_CR, 1'b1, ERR_NONE);
                    CH_LOWER_X, CH_LOWER_U:
                    begin
                        clear_escape();
                        if (eos)
                            emit(8'h00, 1'b0, (c == CH_LOWER_X) ? ERR_HEX2 : ERR_HEX4);
                        else
                            dec_phase = (c == CH_LOWER_X) ? PH_HEX2 : PH_HEX4;
                    end
                    default:
                    begin
                        emit(CH_BACKSLASH, 1'b1, ERR_NONE);
                        emit(c, 1'b1, ERR_NONE);
                    end
                endcase
            end
            default:
            begin
                quad = (dec_phase == PH_HEX4);
                need = quad ? 4 : 2;
                err  = quad ? ERR_HEX4 : ERR_HEX2;
                have = dec_count;
                hv   = hex_nibble(c);
                if (!hv[4])
                    dec_bad = 1'b1;
                code     = {dec_code[11:0], hv[3:0]};
                dec_code = code;
                if (have + 1 >= need)
                begin
                    if (dec_bad)
                    begin
                        emit(CH_QUESTION, 1'b1, err);
                    end
                    else if (!quad || code < 16'h0080)
                    begin
                        emit(code[7:0], 1'b1, ERR_NONE);
                    end
                    else if (code < 16'h0800)
                    begin
                        emit({3'b110, code[10:6]}, 1'b1, ERR_NONE);
                        emit({2'b10, code[5:0]}, 1'b1, ERR_NONE);
                    end
                    else
                    begin
                        emit({4'b1110, code[15:12]}, 1'b1, ERR_NONE);
                        emit({2'b10, code[11:6]}, 1'b1, ERR_NONE);
                        emit({2'b10, code[5:0]}, 1'b1, ERR_NONE);
                    end
                    clear_escape();
                end
                else if (eos)
                begin
                    for (int i = 0; i < have; i++)
                        emit(dec_held[i], 1'b1, err);
                    emit(c, 1'b1, err);
                    clear_escape();
                end
                else
                begin
                    dec_held[have] = c;
                    dec_count      = dec_count + 2'd1;
                end
            end
        endcase
        if (eos)
        begin
            clear_escape();
            if (step_res.size() > 0)
                step_res[step_res.size() - 1].final_res = 1'b1;
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + {4'd0, v};
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] bad_digit();
        logic [7:0] b;
        logic [4:0] hv;
        case ($urandom_range(0, 3))
            0: return CH_BACKSLASH;
            1: return CH_QUOTE;
            default:
            begin
                do
                begin
                    b  = 8'($urandom_range(0, 255));
                    hv = hex_nibble(b);
                end
                while (hv[4]);
                return b;
            end
        endcase
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        body_bytes = {body_bytes, b};
    endfunction

    function automatic void push_digits(input logic [15:0] code, input int count,
                                        input int bad_odds);
        for (int i = count - 1; i >= 0; i--)
        begin
            if ($urandom_range(0, bad_odds - 1) == 0)
                add_byte(bad_digit());
            else
                add_byte(hex_char(code[4 * i +: 4]));
        end
    endfunction

    // mostly well-formed escapes, some noise, some strings cut short
    function automatic void build_string();
        logic [7:0]  b;
        logic [15:0] code;
        int          keep;
        body_bytes.delete();
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_BACKSLASH)
                        b = ~b;
                    add_byte(b);
                end
                2:
                begin
                    add_byte(CH_BACKSLASH);
                    add_byte(simple_esc[$urandom_range(0, 8)]);
                end
                3:
                begin
                    add_byte(CH_BACKSLASH);
                    add_byte(8'($urandom_range(0, 255)));
                end
                4, 5:
                begin
                    add_byte(CH_BACKSLASH);
                    add_byte(CH_LOWER_X);
                    push_digits(16'($urandom_range(0, 255)), 2, 8);
                end
                6, 7, 8:
                begin
                    case ($urandom_range(0, 4))
                        0: code = 16'($urandom_range(16'h0000, 16'h007F));
                        1: code = 16'($urandom_range(16'h0080, 16'h07FF));
                        2: code = 16'($urandom_range(16'h0800, 16'hFFFF));
                        3: code = 16'($urandom_range(16'hD800, 16'hDFFF));
                        default: code = code_edges[$urandom_range(0, 5)];
                    endcase
                    add_byte(CH_BACKSLASH);
                    add_byte(CH_LOWER_U);
                    push_digits(code, 4, 12);
                end
                default:
                begin
                    add_byte(8'($urandom_range(0, 255)));
                end
            endcase
        end
        if ($urandom_range(0, 4) == 0)
        begin
            keep = $urandom_range(1, body_bytes.size());
            while (body_bytes.size() > keep)
                void'(body_bytes.pop_back());
        end
    endfunction

    task automatic send_byte(input item_t it, input logic fixed, input result_t res);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        decode_byte(it);
        if (fixed)
        begin
            decoded_due = {decoded_due, res};
        end
        else
        begin
            foreach (step_res[i])
                decoded_due = {decoded_due, step_res[i]};
        end
        burst_left--;
        @(negedge clk);
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        if (drain)
        begin
            pop <= 1'b1;
        end
        else
        begin
            if (pat_left == 0)
            begin
                pat_left  = $urandom_range(16, 80);
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : (16'($urandom) | 16'h0001);
            end
            pop <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            pat_left--;
        end
    end

    // result transfer check
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (decoded_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output: char %h has %b final %b err %0d",
                             result.char_out, result.has_char, result.final_res,
                             result.escape_error);
            end
            else
            begin
                want = decoded_due.pop_front();
                if (result.char_out !== want.char_out || result.has_char !== want.has_char
                    || result.final_res !== want.final_res
                    || result.escape_error !== want.escape_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected char %h has %b final %b err %0d",
                                 want.char_out, want.has_char, want.final_res,
                                 want.escape_error);
                        $display("          got      char %h has %b final %b err %0d",
                                 result.char_out, result.has_char, result.final_res,
                                 result.escape_error);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_json_string_unescape_core NOT OK");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        item_t it;
        int    sent;
        sent = 0;
        foreach (dec_held[i])
            dec_held[i] = 8'd0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int k = 0; k < $size(directed_rows); k++)
        begin
            it.char_in       = directed_rows[k].ch;
            it.end_of_string = directed_rows[k].eos;
            send_byte(it, directed_rows[k].fixed, directed_rows[k].res);
        end
        while (sent < RANDOM_BYTES)
        begin
            build_string();
            for (int k = 0; k < body_bytes.size(); k++)
            begin
                it.char_in       = body_bytes[k];
                it.end_of_string = (k == body_bytes.size() - 1);
                send_byte(it, 1'b0, NO_FIXED);
                sent++;
            end
        end
        push <= 1'b0;
        while (decoded_due.size() != 0)
            @(posedge clk);
        drain = 1'b1;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_json_string_unescape_core OK");
        else
            $display("tb_json_string_unescape_core NOT OK");
        $finish;
    end

endmodule
